### hw/rtl/ps2sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 scancode decoder package
// Scancode values, modifier bit positions and result codes shared by the
// channel interfaces and the decoder.
// ----------------------------------------------------------------------------
package ps2sc_pkg;

  localparam int unsigned CodeWidth  = 8;
  localparam int unsigned FlagsWidth = 8;

  typedef logic [CodeWidth-1:0]  scan_code_t;
  typedef logic [FlagsWidth-1:0] key_flags_t;

  // Set-2 scancodes that the decoder acts on.
  localparam scan_code_t CodeRelease  = 8'hF0;
  localparam scan_code_t CodeExtend   = 8'hE0;
  localparam scan_code_t CodeCtrl     = 8'h14;
  localparam scan_code_t CodeRShift   = 8'h59;
  localparam scan_code_t CodeNumLock  = 8'h77;
  localparam scan_code_t CodeCapsLock = 8'h58;
  localparam scan_code_t CodeScroll   = 8'h7E;
  localparam scan_code_t CodeAlt      = 8'h11;
  localparam scan_code_t CodeTab      = 8'h0D;

  // Bit positions within the modifier byte.
  localparam int unsigned BitShift    = 0;
  localparam int unsigned BitAlt      = 1;
  localparam int unsigned BitCtrl     = 2;
  localparam int unsigned BitNum      = 4;
  localparam int unsigned BitCaps     = 5;
  localparam int unsigned BitScroll   = 6;
  localparam int unsigned BitExtended = 7;

  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_CHAR   = 2'd1,
    EVT_FOCUS  = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    TBL_EXTENDED  = 2'd0,
    TBL_CONTROL   = 2'd1,
    TBL_SHIFTED   = 2'd2,
    TBL_UNSHIFTED = 2'd3
  } table_sel_t;

endpackage : ps2sc_pkg
`default_nettype wire

### hw/rtl/ps2sc_scan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scancode channel
// Valid/ready channel carrying one raw keyboard byte per transaction.
// ----------------------------------------------------------------------------
interface ps2sc_scan_if;
  logic                  valid;
  logic                  ready;
  ps2sc_pkg::scan_code_t scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink   (input valid, input scan_code, output ready);
endinterface : ps2sc_scan_if
`default_nettype wire

### hw/rtl/ps2sc_event_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decoder result channel
// Valid/ready channel carrying one decoded key event per transaction.
// ----------------------------------------------------------------------------
interface ps2sc_event_if;
  logic                   valid;
  logic                   ready;
  ps2sc_pkg::event_kind_t event_kind;
  ps2sc_pkg::table_sel_t  table_select;
  ps2sc_pkg::scan_code_t  key_code;
  ps2sc_pkg::key_flags_t  modifier_flags;

  modport source (output valid, output event_kind, output table_select,
                  output key_code, output modifier_flags, input ready);
  modport sink   (input valid, input event_kind, input table_select,
                  input key_code, input modifier_flags, output ready);
endinterface : ps2sc_event_if
`default_nettype wire

### hw/rtl/ps2_scancode_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 scancode set-2 decoder
// Turns raw keyboard bytes into key events, tracking modifiers and locks.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                                       Per transaction
//  scan     in         scan_code                                     one keyboard byte
//  result   out        event_kind, table_select, key_code,           one event per byte
//                      modifier_flags
//
// Every accepted byte gives exactly one result transaction, after passing
// through the input register and then the result register.
// One byte is taken in every cycle; the only limit is the result register,
// which frees up in the same cycle that its contents are taken.
// A stall on the result side backs up through the input register to scan.ready.
// Synchronous reset empties both registers and clears the release flag and the
// modifier byte.
//
// The modifier byte holds shift (bit 0), alt (bit 1), ctrl (bit 2), num lock
// (bit 4), caps lock (bit 5), scroll lock (bit 6) and the extended prefix flag
// (bit 7). The decoder state is updated when a byte moves from the input
// register into the result register, so bytes are decoded strictly in order.
// ----------------------------------------------------------------------------
module ps2_scancode_decoder (
  input  wire logic     clk,
  input  wire logic     rst,
  ps2sc_scan_if.sink    scan,
  ps2sc_event_if.source result
);

  // Input register.
  logic                  in_valid;
  ps2sc_pkg::scan_code_t in_code;

  // Decoder state.
  logic                  release_pending;
  logic                  release_pending_next;
  ps2sc_pkg::key_flags_t key_flags;
  ps2sc_pkg::key_flags_t key_flags_next;

  // Result register.
  logic                   out_valid;
  ps2sc_pkg::event_kind_t out_kind;
  ps2sc_pkg::table_sel_t  out_table;
  ps2sc_pkg::scan_code_t  out_code;
  ps2sc_pkg::key_flags_t  out_flags;

  // Decoded values for the byte in the input register.
  ps2sc_pkg::event_kind_t kind_next;
  ps2sc_pkg::table_sel_t  table_next;
  ps2sc_pkg::scan_code_t  code_next;

  logic out_load;
  logic in_load;

  // The result register can take a new event when it is empty or being read.
  assign out_load  = in_valid && (!out_valid || result.ready);
  assign scan.ready = !in_valid || out_load;
  assign in_load   = scan.valid && scan.ready;

  // Decode one byte against the current state.
  always_comb begin
    release_pending_next = release_pending;
    key_flags_next       = key_flags;
    kind_next            = ps2sc_pkg::EVT_NONE;
    table_next           = ps2sc_pkg::TBL_EXTENDED;
    code_next            = '0;

    priority if (in_code == ps2sc_pkg::CodeRelease) begin
      release_pending_next = 1'b1;
    end else if (in_code == ps2sc_pkg::CodeExtend) begin
      key_flags_next[ps2sc_pkg::BitExtended] = 1'b1;
    end else begin
      release_pending_next = 1'b0;
      unique case (in_code)
        ps2sc_pkg::CodeCtrl: begin
          key_flags_next[ps2sc_pkg::BitCtrl] = !release_pending;
        end
        ps2sc_pkg::CodeRShift: begin
          key_flags_next[ps2sc_pkg::BitShift] = !release_pending;
        end
        ps2sc_pkg::CodeAlt: begin
          key_flags_next[ps2sc_pkg::BitAlt] = !release_pending;
        end
        // Lock keys toggle on make only; their break does nothing.
        ps2sc_pkg::CodeNumLock: begin
          key_flags_next[ps2sc_pkg::BitNum] =
            key_flags[ps2sc_pkg::BitNum] ^ !release_pending;
        end
        ps2sc_pkg::CodeCapsLock: begin
          key_flags_next[ps2sc_pkg::BitCaps] =
            key_flags[ps2sc_pkg::BitCaps] ^ !release_pending;
        end
        ps2sc_pkg::CodeScroll: begin
          key_flags_next[ps2sc_pkg::BitScroll] =
            key_flags[ps2sc_pkg::BitScroll] ^ !release_pending;
        end
        default: begin
          // Break codes of ordinary keys are swallowed.
          if (!release_pending) begin
            if (in_code == ps2sc_pkg::CodeTab && key_flags[ps2sc_pkg::BitAlt]) begin
              kind_next = ps2sc_pkg::EVT_FOCUS;
            end else begin
              kind_next = ps2sc_pkg::EVT_CHAR;
              code_next = in_code;
              priority if (key_flags[ps2sc_pkg::BitExtended]) begin
                table_next = ps2sc_pkg::TBL_EXTENDED;
              end else if (key_flags[ps2sc_pkg::BitCtrl]) begin
                table_next = ps2sc_pkg::TBL_CONTROL;
              end else if (key_flags[ps2sc_pkg::BitShift]) begin
                table_next = ps2sc_pkg::TBL_SHIFTED;
              end else begin
                table_next = ps2sc_pkg::TBL_UNSHIFTED;
              end
            end
          end
        end
      endcase
      // The extended prefix applies to exactly one following code.
      key_flags_next[ps2sc_pkg::BitExtended] = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      release_pending <= 1'b0;
      key_flags       <= '0;
    end else begin
      if (in_load) begin
        in_valid <= 1'b1;
      end else if (out_load) begin
        in_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid       <= 1'b1;
        release_pending <= release_pending_next;
        key_flags       <= key_flags_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_code <= scan.scan_code;
    end
    if (out_load) begin
      out_kind  <= kind_next;
      out_table <= table_next;
      out_code  <= code_next;
      out_flags <= key_flags_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.event_kind     = out_kind;
  assign result.table_select   = out_table;
  assign result.key_code       = out_code;
  assign result.modifier_flags = out_flags;

endmodule : ps2_scancode_decoder
`default_nettype wire

### tb/tb_ps2_scancode_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 scancode decoder testbench
// Feeds directed and random set-2 byte streams into the decoder, predicts the
// key event for every accepted byte and checks each result transaction in
// order, with random idling on both channels and a long result-side stall.
// ----------------------------------------------------------------------------
module tb_ps2_scancode_decoder;

  // Stimulus size, the point at which the sender waits for a drain, and the result-side stall.
  localparam int unsigned TotalItems  = 1050;
  localparam int unsigned DrainPoint  = 500;
  localparam int unsigned StallPoint  = 300;
  localparam int unsigned StallCycles = 200;
  localparam int unsigned SettleCycles = 10;

  // One decoded key event, laid out as the result channel carries it.
  typedef struct packed {
    ps2sc_pkg::event_kind_t kind;
    ps2sc_pkg::table_sel_t  tsel;
    ps2sc_pkg::scan_code_t  code;
    ps2sc_pkg::key_flags_t  flags;
  } key_event_t;

  logic clk;
  logic rst;

  ps2sc_scan_if  scan_ch ();
  ps2sc_event_if result_ch ();

  ps2_scancode_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan_ch),
    .result (result_ch)
  );

  // Bytes still to be offered, and the key events that accepted bytes must
  // produce, oldest first.
  ps2sc_pkg::scan_code_t pending_codes[$];
  key_event_t            expected_events[$];

  // Private copy of the decoder state, advanced once per accepted byte.
  logic                  release_seen;
  ps2sc_pkg::key_flags_t flags_model;

  int unsigned bytes_sent;
  int unsigned events_seen;
  int unsigned error_count;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_off;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap lengths are mostly zero or short, occasionally long. Every fourth
  // block of 128 transactions runs flat out so that back-to-back traffic is
  // seen as well.
  function automatic int unsigned idle_len(input int unsigned seq);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (((seq / 128) % 4) == 3) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Decode one scancode against the model state and queue the key event
  // that the decoder must report for it. Table choice and alt+tab detection
  // look at the modifier byte as it stood before this byte.
  task automatic decode_scan_code(input ps2sc_pkg::scan_code_t sc);
    ps2sc_pkg::key_flags_t flags_prior;
    key_event_t            ev;
    flags_prior = flags_model;
    ev.kind = ps2sc_pkg::EVT_NONE;
    ev.tsel = ps2sc_pkg::TBL_EXTENDED;
    ev.code = '0;
    if (sc == ps2sc_pkg::CodeRelease) begin
      // A release prefix only arms the break for the next code.
      release_seen = 1'b1;
    end else if (sc == ps2sc_pkg::CodeExtend) begin
      // The extended prefix leaves a pending release alone, so F0 E0 xx
      // also decodes as an extended break.
      flags_model[ps2sc_pkg::BitExtended] = 1'b1;
    end else begin
      case (sc)
        ps2sc_pkg::CodeCtrl: begin
          flags_model[ps2sc_pkg::BitCtrl] = !release_seen;
          release_seen = 1'b0;
        end
        ps2sc_pkg::CodeRShift: begin
          flags_model[ps2sc_pkg::BitShift] = !release_seen;
          release_seen = 1'b0;
        end
        ps2sc_pkg::CodeAlt: begin
          flags_model[ps2sc_pkg::BitAlt] = !release_seen;
          release_seen = 1'b0;
        end
        ps2sc_pkg::CodeNumLock: begin
          if (!release_seen)
            flags_model[ps2sc_pkg::BitNum] = ~flags_model[ps2sc_pkg::BitNum];
          release_seen = 1'b0;
        end
        ps2sc_pkg::CodeCapsLock: begin
          if (!release_seen)
            flags_model[ps2sc_pkg::BitCaps] = ~flags_model[ps2sc_pkg::BitCaps];
          release_seen = 1'b0;
        end
        ps2sc_pkg::CodeScroll: begin
          if (!release_seen)
            flags_model[ps2sc_pkg::BitScroll] = ~flags_model[ps2sc_pkg::BitScroll];
          release_seen = 1'b0;
        end
        default: begin
          if (release_seen) begin
            // Break codes of ordinary keys are swallowed.
            release_seen = 1'b0;
          end else if (sc == ps2sc_pkg::CodeTab && flags_prior[ps2sc_pkg::BitAlt]) begin
            ev.kind = ps2sc_pkg::EVT_FOCUS;
          end else begin
            ev.kind = ps2sc_pkg::EVT_CHAR;
            ev.code = sc;
            if (flags_prior[ps2sc_pkg::BitExtended])   ev.tsel = ps2sc_pkg::TBL_EXTENDED;
            else if (flags_prior[ps2sc_pkg::BitCtrl])  ev.tsel = ps2sc_pkg::TBL_CONTROL;
            else if (flags_prior[ps2sc_pkg::BitShift]) ev.tsel = ps2sc_pkg::TBL_SHIFTED;
            else ev.tsel = ps2sc_pkg::TBL_UNSHIFTED;
          end
        end
      endcase
      // The extended flag lasts for exactly one following code.
      flags_model[ps2sc_pkg::BitExtended] = 1'b0;
    end
    ev.flags = flags_model;
    expected_events.push_back(ev);
  endtask

  // Queue one well-formed key sequence: optional extended prefix, optional
  // release prefix, then the key itself.
  task automatic queue_key(input ps2sc_pkg::scan_code_t key, input bit ext,
                           input bit brk);
    if (ext) pending_codes.push_back(ps2sc_pkg::CodeExtend);
    if (brk) pending_codes.push_back(ps2sc_pkg::CodeRelease);
    pending_codes.push_back(key);
  endtask

  // Stimulus and end of run. The queue of bytes is filled while reset is
  // still held, before the driver starts taking from it.
  initial begin
    int unsigned           r;
    int unsigned           k;
    ps2sc_pkg::scan_code_t key;
    rst = 1'b1;

    // Directed part: field extremes, every modifier on make and break, every
    // lock on make and num lock on break, alt+tab with and without alt held,
    // the extended table and an extended break.
    pending_codes.push_back(8'h00);
    pending_codes.push_back(8'hFF);
    queue_key(ps2sc_pkg::CodeCtrl, 1'b0, 1'b0);
    pending_codes.push_back(8'h1C);
    queue_key(ps2sc_pkg::CodeCtrl, 1'b0, 1'b1);
    queue_key(ps2sc_pkg::CodeRShift, 1'b0, 1'b0);
    pending_codes.push_back(8'h1C);
    queue_key(ps2sc_pkg::CodeRShift, 1'b0, 1'b1);
    queue_key(ps2sc_pkg::CodeNumLock, 1'b0, 1'b0);
    queue_key(ps2sc_pkg::CodeCapsLock, 1'b0, 1'b0);
    queue_key(ps2sc_pkg::CodeScroll, 1'b0, 1'b0);
    queue_key(ps2sc_pkg::CodeNumLock, 1'b0, 1'b1);
    queue_key(ps2sc_pkg::CodeAlt, 1'b0, 1'b0);
    queue_key(ps2sc_pkg::CodeTab, 1'b0, 1'b0);
    queue_key(ps2sc_pkg::CodeAlt, 1'b0, 1'b1);
    queue_key(ps2sc_pkg::CodeTab, 1'b0, 1'b0);
    queue_key(8'h1C, 1'b1, 1'b0);
    queue_key(8'h1C, 1'b1, 1'b1);

    // Random part: mostly well-formed key sequences with random content,
    // the rest raw bytes and prefixes left dangling.
    while (pending_codes.size() < TotalItems) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        pending_codes.push_back(ps2sc_pkg::scan_code_t'($urandom_range(0, 255)));
      end else if (r < 15) begin
        pending_codes.push_back(($urandom_range(0, 1) == 0) ?
                                ps2sc_pkg::CodeRelease : ps2sc_pkg::CodeExtend);
      end else begin
        k = $urandom_range(0, 11);
        case (k)
          0:       key = ps2sc_pkg::CodeCtrl;
          1:       key = ps2sc_pkg::CodeRShift;
          2:       key = ps2sc_pkg::CodeAlt;
          3:       key = ps2sc_pkg::CodeNumLock;
          4:       key = ps2sc_pkg::CodeCapsLock;
          5:       key = ps2sc_pkg::CodeScroll;
          6:       key = ps2sc_pkg::CodeTab;
          default: key = ps2sc_pkg::scan_code_t'($urandom_range(0, 255));
        endcase
        queue_key(key, $urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for every byte to be taken and every event to be checked, then
    // wait SettleCycles more so that any stray result shows.
    while (pending_codes.size() != 0 || expected_events.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (error_count == 0 && expected_events.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Driver. A byte is held on the channel until its transaction completes;
  // the model is advanced at that edge. At DrainPoint the sender waits until
  // every outstanding event has been returned.
  always @(posedge clk) begin
    logic next_valid;
    logic accepted;
    if (rst) begin
      scan_ch.valid     <= 1'b0;
      scan_ch.scan_code <= '0;
      release_seen      = 1'b0;
      flags_model       = '0;
      bytes_sent        = 0;
      send_gap          = 0;
    end else begin
      accepted = scan_ch.valid && scan_ch.ready;
      if (accepted) begin
        decode_scan_code(scan_ch.scan_code);
        void'(pending_codes.pop_front());
        bytes_sent++;
        // No gaps while the receiver is holding off, so that the decoder
        // fills up and stalls its input.
        send_gap = (hold_off > 0) ? 0 : idle_len(bytes_sent);
      end
      if (!scan_ch.valid || accepted) begin
        if (send_gap > 0) begin
          send_gap--;
          next_valid = 1'b0;
        end else if (pending_codes.size() != 0 &&
                     !(bytes_sent == DrainPoint && expected_events.size() != 0)) begin
          next_valid = 1'b1;
          scan_ch.scan_code <= pending_codes[0];
        end else begin
          next_valid = 1'b0;
        end
        scan_ch.valid <= next_valid;
      end
    end
  end

  // Monitor. Each result transaction is checked field by field against the
  // oldest expected event. After StallPoint results the receiver holds off
  // for a long stretch, counted here.
  always @(posedge clk) begin
    key_event_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      events_seen = 0;
      error_count = 0;
      recv_gap    = 0;
      hold_off    = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_events.size() == 0) begin
          $error("result transaction with no expected event: kind %0d code %h",
                 result_ch.event_kind, result_ch.key_code);
          error_count++;
        end else begin
          want = expected_events.pop_front();
          if (result_ch.event_kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, result_ch.event_kind);
            error_count++;
          end
          if (result_ch.table_select !== want.tsel) begin
            $error("table_select: expected %0d, actual %0d", want.tsel,
                   result_ch.table_select);
            error_count++;
          end
          if (result_ch.key_code !== want.code) begin
            $error("key_code: expected %h, actual %h", want.code, result_ch.key_code);
            error_count++;
          end
          if (result_ch.modifier_flags !== want.flags) begin
            $error("modifier_flags: expected %h, actual %h", want.flags,
                   result_ch.modifier_flags);
            error_count++;
          end
        end
        events_seen++;
        if (events_seen == StallPoint) hold_off = StallCycles;
        else recv_gap = idle_len(events_seen);
      end
      if (hold_off > 0) begin
        hold_off--;
        result_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule : tb_ps2_scancode_decoder
